// ----- rtl/tgr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants and the 5x7 font lookup for the glyph rasterizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int GLYPH_W    = 5;
  localparam int GLYPH_H    = 7;
  localparam int GLYPH_BITS = GLYPH_W * GLYPH_H;
  localparam int COORD_W    = 13;

  localparam logic signed [COORD_W:0] COORD_HI = 14'sd4095;
  localparam logic signed [COORD_W:0] COORD_LO = -14'sd4096;

  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_FOLD = 8'h20;

  typedef logic [GLYPH_BITS-1:0] glyph_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } tgr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // take the input item, look up its glyph, advance the pen
    logic step;  // move the scan to the next glyph bit
    logic emit;  // write the current square into the output register
  } tgr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic glyph_lit;  // glyph of the offered item has at least one set bit
    logic cur_bit;    // glyph bit under the scan position is set
    logic rest_zero;  // no set bit follows the scan position
    logic out_free;   // output register can take a square this cycle
  } tgr_stat_t;

  // Saturate a widened coordinate to the signed 13-bit range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
    logic [COORD_W-1:0] r;
    if (v > COORD_HI) begin
      r = COORD_HI[COORD_W-1:0];
    end else if (v < COORD_LO) begin
      r = COORD_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Glyph bits, top row in the highest bits, each row's left column first.
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [7:0] c;
    glyph_t     g;
    c = code;
    if (code inside {[LOWER_A:LOWER_Z]}) begin
      c = code - CASE_FOLD;
    end
    case (c)
      "-":     g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      ".":     g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
      ":":     g = {5'h00, 5'h06, 5'h06, 5'h00, 5'h06, 5'h06, 5'h00};
      "/":     g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
      "0":     g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1":     g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "2":     g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      "3":     g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "4":     g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5":     g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      "6":     g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7":     g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8":     g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9":     g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      "A":     g = {5'h04, 5'h0A, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
      "B":     g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "C":     g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      "D":     g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
      "E":     g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "F":     g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      "G":     g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      "H":     g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I":     g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "J":     g = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      "K":     g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "L":     g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M":     g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      "N":     g = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
      "O":     g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P":     g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "Q":     g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      "R":     g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "S":     g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "T":     g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U":     g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V":     g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      "W":     g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      "X":     g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      "Y":     g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      "Z":     g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      "_":     g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
      default: g = '0;  // space and every code outside the font
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/text_glyph_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_rasterizer
// 5x7 character generator that draws each lit glyph bit as a pixel square.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer carries
// in_*      slave      one character, its string start flag, x, y and color
// out_*     master     one square: corner, color, last square of the character
//
// A character is taken when the block is idle; its glyph is then scanned one
// bit per cycle, unless a lit bit waits on a stalled output, from the top-left
// bit to the last lit bit, and a blank character is taken without a scan. A
// single scan position walks the 35-bit glyph register. Reset (rst_n low at
// a clock edge) empties the output register, returns the controller to idle
// and sets the pen to zero. A stalled output holds the scan on a lit bit;
// unlit bits keep moving, and a new character is accepted while the last
// square waits.
//
module text_glyph_rasterizer
  import tgr_pkg::*;
#(
  parameter int PIXEL_SCALE = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Character input.
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: char_code[7:0], start_x[20:8], base_y[33:21],
  // text_color[57:34], zero padding[63:58].
  input  logic [63:0] in_tdata,
  // Fields from bit 0: string_start[0].
  input  logic        in_tuser,
  // Square output.
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: square_left[12:0], square_top[25:13], red[33:26],
  // green[41:34], blue[49:42], zero padding[55:50].
  output logic [55:0] out_tdata,
  // Marks the final square of a character (last_square).
  output logic        out_tlast
);

  tgr_cmd_t  cmd;
  tgr_stat_t stat;

  // The controller sequences accept and scan; the datapath holds every data value.
  tgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tgr_datapath #(
    .PIXEL_SCALE (PIXEL_SCALE)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ----- rtl/tgr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_ctrl
// Controller: accepts a character, then walks its glyph bits one per cycle while not stalled.
// ----------------------------------------------------------------------------
module tgr_ctrl
  import tgr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tgr_stat_t stat,
  output tgr_cmd_t  cmd
);

  tgr_state_t state_r, state_nxt;
  logic       stall;

  // A lit bit waits for room in the output register.
  assign stall = stat.cur_bit && !stat.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && stat.glyph_lit) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall && stat.rest_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN: begin
        cmd.step = !stall;
        cmd.emit = stat.cur_bit && stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/tgr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_datapath
// Pen, glyph shift register, square offsets and the output register.
// ----------------------------------------------------------------------------
module tgr_datapath
  import tgr_pkg::*;
#(
  parameter int PIXEL_SCALE = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic        out_tlast,
  input  tgr_cmd_t    cmd,
  output tgr_stat_t   stat
);

  localparam int XOFF_W  = $clog2((GLYPH_W - 1) * PIXEL_SCALE + 1);
  localparam int YOFF_W  = $clog2(GLYPH_H * PIXEL_SCALE + 1);
  localparam int ADVANCE = (GLYPH_W + 1) * PIXEL_SCALE;
  localparam int COL_W   = $clog2(GLYPH_W);

  // Input fields.
  logic [7:0]         in_char;
  logic               in_start;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [23:0]        in_color;
  glyph_t             in_glyph;

  assign in_char  = in_tdata[7:0];
  assign in_start = in_tuser;
  assign in_x     = in_tdata[20:8];
  assign in_y     = in_tdata[33:21];
  assign in_color = in_tdata[57:34];
  assign in_glyph = glyph_lookup(in_char);

  // Character state.
  logic [COORD_W-1:0] pen_r, cx_r, y_r;
  logic [23:0]        color_r;
  glyph_t             mask_r;
  logic [COL_W-1:0]   col_r;
  logic [XOFF_W-1:0]  xoff_r;
  logic [YOFF_W-1:0]  yoff_r;
  logic [COORD_W-1:0] cx_sel;
  logic [COORD_W:0]   pen_sum;

  assign cx_sel  = in_start ? in_x : pen_r;
  assign pen_sum = {cx_sel[COORD_W-1], cx_sel} + (COORD_W + 1)'(ADVANCE);

  // Square corner for the current scan position.
  logic [COORD_W:0]   left_sum, top_sum;
  assign left_sum = {cx_r[COORD_W-1], cx_r} + (COORD_W + 1)'(xoff_r);
  assign top_sum  = {y_r[COORD_W-1], y_r} + (COORD_W + 1)'(yoff_r);

  // Output register.
  logic               out_valid_r;
  logic [COORD_W-1:0] sq_left_r, sq_top_r;
  logic [23:0]        sq_color_r;
  logic               sq_last_r;

  assign stat.glyph_lit = |in_glyph;
  assign stat.cur_bit   = mask_r[GLYPH_BITS-1];
  assign stat.rest_zero = ~|mask_r[GLYPH_BITS-2:0];
  assign stat.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= '0;
    end else if (cmd.load) begin
      pen_r <= sat_coord($signed(pen_sum));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r    <= cx_sel;
      y_r     <= in_y;
      color_r <= in_color;
      mask_r  <= in_glyph;
      col_r   <= '0;
      xoff_r  <= '0;
      yoff_r  <= '0;
    end else if (cmd.step) begin
      mask_r <= {mask_r[GLYPH_BITS-2:0], 1'b0};
      if (col_r == COL_W'(GLYPH_W - 1)) begin
        col_r  <= '0;
        xoff_r <= '0;
        yoff_r <= yoff_r + YOFF_W'(PIXEL_SCALE);
      end else begin
        col_r  <= col_r + 1'b1;
        xoff_r <= xoff_r + XOFF_W'(PIXEL_SCALE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sq_left_r  <= sat_coord($signed(left_sum));
      sq_top_r   <= sat_coord($signed(top_sum));
      sq_color_r <= color_r;
      sq_last_r  <= stat.rest_zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = sq_last_r;
  assign out_tdata  = {6'b0, sq_color_r[7:0], sq_color_r[15:8], sq_color_r[23:16],
                       sq_top_r, sq_left_r};

endmodule

// ----- rtl/tgr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_checker
// Port-level checks on the glyph rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module tgr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  // A square that was not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("square changed while stalled");

  // The padding above the blue field is always zero.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:50] == 6'b0)
    else $error("output padding not zero");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("square offered right after reset");

  // While a square that is not the last of its character waits, no new character is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !out_tlast |-> !in_tready)
    else $error("character accepted during a scan");

endmodule

bind text_glyph_rasterizer tgr_checker u_tgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 5x7 glyph rasterizer. Characters are streamed
// into the block, a local model of the font, pen and saturation rules predicts
// every square, and each square leaving the block is checked field by field.
// ----------------------------------------------------------------------------
module tb;

  // Square size used both by the block instance and by the local model.
  localparam int SCALE = 2;

  localparam int COORD_MAX = 4095;
  localparam int COORD_MIN = -4096;

  // Hard stop for the run, far above the slowest legal run even with heavy
  // output backpressure and long gaps on the input side.
  localparam int CYCLE_LIMIT = 600000;

  // Cycles allowed after the last square before the final verdict.
  localparam int DRAIN_CYCLES = 60;

  // Only this many failures are printed in detail.
  localparam int SHOW_MAX = 10;

  // One drawn square as the output channel carries it.
  typedef struct packed {
    logic signed [12:0] left;
    logic signed [12:0] top;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last;
  } square_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // char_code, start_x, base_y, text_color, padding
  logic        in_tuser;   // string_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;  // square_left, square_top, red, green, blue, padding
  logic        out_tlast;  // last_square

  // Squares predicted for accepted characters, oldest first.
  square_t pending_squares[$];

  // Pen position of the local model; it follows the block's own pen.
  logic signed [12:0] model_pen;

  int failures = 0;
  int cycle_count = 0;

  // Idle and stall odds in percent, changed from phase to phase.
  int sender_idle_pct;
  int recv_stall_pct;

  text_glyph_rasterizer #(
    .PIXEL_SCALE(SCALE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local model of the font and the drawing rules.
  // --------------------------------------------------------------------------

  // Glyph of a character, top row in the highest five bits and the leftmost
  // column as the highest bit of each row. Lower case is folded first; any
  // code without a glyph, the space included, is blank.
  function automatic logic [34:0] font_bits(input logic [7:0] code);
    logic [7:0]  ch;
    logic [34:0] rows;
    ch = (code >= 8'h61 && code <= 8'h7A) ? code - 8'h20 : code;
    case (ch)
      "-": rows = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      ".": rows = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
      ":": rows = {5'h00, 5'h06, 5'h06, 5'h00, 5'h06, 5'h06, 5'h00};
      "/": rows = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
      "0": rows = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": rows = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "2": rows = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      "3": rows = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "4": rows = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      "6": rows = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": rows = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": rows = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      "A": rows = {5'h04, 5'h0A, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
      "B": rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "C": rows = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      "D": rows = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
      "E": rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "F": rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      "G": rows = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      "H": rows = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I": rows = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "J": rows = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      "K": rows = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "L": rows = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": rows = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      "N": rows = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
      "O": rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P": rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "Q": rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      "R": rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "S": rows = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "T": rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      "W": rows = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      "X": rows = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      "Y": rows = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      "Z": rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      "_": rows = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
      default: rows = '0;
    endcase
    return rows;
  endfunction

  // Clamp a wide coordinate into the signed 13-bit range.
  function automatic logic signed [12:0] clamp_coord(input int v);
    logic signed [12:0] r;
    if (v > COORD_MAX) begin
      r = 13'sd4095;
    end else if (v < COORD_MIN) begin
      r = -13'sd4096;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

  // Queue up the squares of one accepted character and move the pen on.
  task automatic rasterize_char(input logic [7:0] code, input logic start_flag,
                                input logic signed [12:0] sx,
                                input logic signed [12:0] y,
                                input logic [23:0] color);
    logic [34:0] glyph;
    square_t     sq;
    int          pen;
    int          lit;
    int          idx;
    glyph = font_bits(code);
    if (start_flag) begin
      model_pen = sx;
    end
    pen = model_pen;
    lit = 0;
    for (int row = 0; row < 7; row++) begin
      for (int col = 0; col < 5; col++) begin
        if (glyph[34 - (row * 5 + col)]) begin
          sq.left  = clamp_coord(pen + col * SCALE);
          sq.top   = clamp_coord(int'(y) + row * SCALE);
          sq.red   = color[23:16];
          sq.green = color[15:8];
          sq.blue  = color[7:0];
          sq.last  = 1'b0;
          pending_squares.push_back(sq);
          lit++;
        end
      end
    end
    // Only the final square of a lit character carries the last flag; a blank
    // character leaves nothing behind in the queue.
    if (lit > 0) begin
      idx = pending_squares.size() - 1;
      pending_squares[idx].last = 1'b1;
    end
    model_pen = clamp_coord(pen + 6 * SCALE);
  endtask

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------

  // Offer one character and hold it until the block takes it. Inputs change
  // only at the falling edge; the transfer is seen at the rising edge. When
  // the sender decides to idle first, tvalid drops for whole cycles and the
  // data bus carries junk meanwhile.
  task automatic send_char(input logic [7:0] code, input logic start_flag,
                           input logic signed [12:0] sx,
                           input logic signed [12:0] y,
                           input logic [23:0] color);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
      in_tuser  <= 1'($urandom_range(1));
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, color, y, sx, code};
    in_tuser  <= start_flag;
    do begin
      @(posedge clk);
    end while (!in_tready);
    rasterize_char(code, start_flag, sx, y, color);
  endtask

  // A random character: mostly letters of either case and digits, then the
  // punctuation of the font, and some codes drawn from the full byte range.
  function automatic logic [7:0] pick_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 40) begin
      c = 8'(8'h41 + $urandom_range(25));
    end else if (r < 60) begin
      c = 8'(8'h61 + $urandom_range(25));
    end else if (r < 75) begin
      c = 8'(8'h30 + $urandom_range(9));
    end else if (r < 87) begin
      case ($urandom_range(5))
        0:       c = " ";
        1:       c = "-";
        2:       c = ".";
        3:       c = ":";
        4:       c = "/";
        default: c = "_";
      endcase
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // A random coordinate, pulled toward both ends of the range now and then
  // so that squares and the pen saturate often.
  function automatic logic signed [12:0] pick_coord();
    int r;
    int v;
    r = $urandom_range(9);
    if (r < 2) begin
      v = COORD_MAX - $urandom_range(80);
    end else if (r < 4) begin
      v = COORD_MIN + $urandom_range(80);
    end else begin
      v = $urandom_range(8191) - 4096;
    end
    return v[12:0];
  endfunction

  // --------------------------------------------------------------------------
  // Output side.
  // --------------------------------------------------------------------------

  // The receiver stalls at random, one decision per cycle.
  always @(negedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic note_failure(input string what, input square_t want_sq,
                              input square_t got_sq);
    failures++;
    if (failures <= SHOW_MAX) begin
      $display("%s at cycle %0d", what, cycle_count);
      $display("  wanted left %0d top %0d rgb %02h%02h%02h last %0b",
               want_sq.left, want_sq.top, want_sq.red, want_sq.green,
               want_sq.blue, want_sq.last);
      $display("  got    left %0d top %0d rgb %02h%02h%02h last %0b",
               got_sq.left, got_sq.top, got_sq.red, got_sq.green,
               got_sq.blue, got_sq.last);
    end
  endtask

  // Every square transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    square_t got_sq;
    square_t want_sq;
    if (rst_n && out_tvalid && out_tready) begin
      got_sq.left  = out_tdata[12:0];
      got_sq.top   = out_tdata[25:13];
      got_sq.red   = out_tdata[33:26];
      got_sq.green = out_tdata[41:34];
      got_sq.blue  = out_tdata[49:42];
      got_sq.last  = out_tlast;
      if (pending_squares.size() == 0) begin
        note_failure("square with no character behind it", '0, got_sq);
      end else begin
        want_sq = pending_squares.pop_front();
        if (got_sq.left !== want_sq.left || got_sq.top !== want_sq.top ||
            got_sq.red !== want_sq.red || got_sq.green !== want_sq.green ||
            got_sq.blue !== want_sq.blue || got_sq.last !== want_sq.last) begin
          note_failure("square mismatch", want_sq, got_sq);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Right after reset the pen is zero, so a character without the string
  // start flag draws at x = 0 whatever start_x says; the next one follows.
  task automatic test_pen_after_reset();
    send_char("A", 1'b0, 13'sd1234, 13'sd100, 24'h123456);
    send_char("1", 1'b0, -13'sd77, 13'sd100, 24'h123456);
    send_char("h", 1'b1, 13'sd0, 13'sd0, 24'h00FF00);
  endtask

  // Case folding at its borders, the space, and codes outside the font that
  // must draw nothing while the pen still moves on.
  task automatic test_folding_and_blanks();
    send_char("z", 1'b1, 13'sd40, 13'sd20, 24'hFF0000);
    send_char("a", 1'b0, 13'sd0, 13'sd20, 24'hFF0000);
    send_char(8'h60, 1'b0, 13'sd0, 13'sd20, 24'hFF0000);
    send_char(8'h7B, 1'b0, 13'sd0, 13'sd20, 24'hFF0000);
    send_char(" ", 1'b0, 13'sd0, 13'sd20, 24'hFF0000);
    send_char(8'h00, 1'b0, 13'sd0, 13'sd20, 24'hFF0000);
    send_char(8'h80, 1'b0, 13'sd0, 13'sd20, 24'hFF0000);
    send_char(8'hFF, 1'b0, 13'sd0, 13'sd20, 24'hFF0000);
    send_char("Q", 1'b0, 13'sd0, 13'sd20, 24'hFF0000);
  endtask

  // Corners and pen at both ends of the coordinate range. A saturated pen stays
  // at the top until a start flag moves it, so later characters pile up there.
  task automatic test_coordinate_saturation();
    send_char("W", 1'b1, 13'sd4095, 13'sd4095, 24'h0000FF);
    send_char("8", 1'b0, 13'sd0, 13'sd4090, 24'h0000FF);
    send_char("8", 1'b1, 13'sd4086, 13'sd4085, 24'h0000FF);
    send_char("M", 1'b0, 13'sd0, 13'sd4085, 24'h0000FF);
    send_char("B", 1'b1, -13'sd4096, -13'sd4096, 24'h0000FF);
    send_char("0", 1'b1, -13'sd4096, -13'sd4096, 24'h0000FF);
    send_char(":", 1'b0, 13'sd0, 13'sd4095, 24'h0000FF);
  endtask

  // Color extremes and alternating bit patterns on every channel.
  task automatic test_color_extremes();
    send_char("8", 1'b1, 13'sd0, 13'sd0, 24'h000000);
    send_char("8", 1'b0, 13'sd0, 13'sd0, 24'hFFFFFF);
    send_char("E", 1'b0, 13'sd0, 13'sd0, 24'hAAAAAA);
    send_char("E", 1'b0, 13'sd0, 13'sd0, 24'h555555);
  endtask

  // Random strings under one idle and stall setting. Each string normally opens with
  // the start flag; now and then it continues from the pen of the previous
  // one. start_x is random on every character, so the block must ignore it
  // whenever the flag is low.
  task automatic test_random_strings(input int idle_pct, input int stall_pct,
                                     input int num_chars);
    int                 sent;
    int                 len;
    logic signed [12:0] y;
    logic [23:0]        color;
    logic               start_flag;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    sent = 0;
    while (sent < num_chars) begin
      len   = $urandom_range(1, 8);
      y     = pick_coord();
      color = 24'($urandom_range(24'hFFFFFF));
      start_flag = ($urandom_range(9) != 0);
      for (int i = 0; i < len; i++) begin
        send_char(pick_char(), (i == 0) ? start_flag : 1'b0, pick_coord(), y,
                  color);
        sent++;
      end
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    model_pen   = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with light idling on both sides.
    sender_idle_pct = 20;
    recv_stall_pct  = 20;
    test_pen_after_reset();
    test_folding_and_blanks();
    test_coordinate_saturation();
    test_color_extremes();

    // Random part: free running, idle sender, stalling receiver, then both.
    test_random_strings(0, 0, 50);
    test_random_strings(73, 0, 50);
    test_random_strings(0, 73, 50);
    test_random_strings(13, 13, 50);

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Let the last character finish; the watchdog covers a hang here.
    while (pending_squares.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
